// ===== src/substitution_decrypt_crib_match_core_macros.svh =====
// assertion macros for the crib match core checker
`ifndef SUBSTITUTION_DECRYPT_CRIB_MATCH_CORE_MACROS_SVH
`define SUBSTITUTION_DECRYPT_CRIB_MATCH_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define SDCM_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdcm assertion failed");

// antecedent implies consequent in the next cycle, off during reset
`define SDCM_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdcm assertion failed");

// condition holds in the cycle after reset is seen
`define SDCM_ASSERT_RST(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("sdcm reset assertion failed");

`endif

// ===== src/sdcm_pkg.sv =====
// package: types and constants shared by the crib match core
`timescale 1ns / 1ps
package sdcm_pkg;

   localparam int MAX_CODE_LEN = 14;
   localparam int WIN_DEPTH    = MAX_CODE_LEN - 1;
   localparam int NUM_CODES    = 3;
   localparam int KEY_WIDTH    = 40;
   localparam int CRIB_LEN_W   = $clog2(MAX_CODE_LEN + 1);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [KEY_WIDTH-1:0] KEY_RESET = 40'h98_7654_3210;

   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_J     = 8'h6A;
   localparam logic [7:0] ASCII_ZERO = 8'h30;

   localparam logic [NUM_CODES-1:0] ALL_CODES = {NUM_CODES{1'b1}};

   // cribs right justified: byte j is the char that sits j places before the newest
   localparam logic [8*MAX_CODE_LEN-1:0] CRIBS [NUM_CODES] = '{
      (8*MAX_CODE_LEN)'("9585:3179"),
      (8*MAX_CODE_LEN)'("6731:6331"),
      (8*MAX_CODE_LEN)'("5214:8140:8081")
   };
   localparam logic [CRIB_LEN_W-1:0] CRIB_LEN [NUM_CODES] = '{
      CRIB_LEN_W'(9), CRIB_LEN_W'(9), CRIB_LEN_W'(14)
   };

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]           plain_byte;
      logic [NUM_CODES-1:0] codes_found;
      logic                 all_found;
      logic                 end_of_message;
   } rsp_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       last_byte;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstatus_type;

endpackage

// ===== src/sdcm_front.sv =====
// front end: key register, letter classification and substitution
`timescale 1ns / 1ps
module sdcm_front import sdcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [KEY_WIDTH-1:0] csr_data,
   input  qstatus_type          q_status,
   output logic                 q_push,
   output qentry_type           q_wdata
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 is_letter;
   logic [7:0]           letter_off;
   logic [3:0]           digit;

   assign csr_ready = 1'b1;
   assign key_in    = (csr_valid && csr_ready) ? csr_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      is_letter  = (req_data.cipher_byte >= CHAR_A) && (req_data.cipher_byte <= CHAR_J);
      letter_off = req_data.cipher_byte - CHAR_A;
      digit      = key_ff[{letter_off[3:0], 2'b00} +: 4];
      q_wdata.last_byte  = req_data.last_byte;
      q_wdata.plain_byte = is_letter ? (ASCII_ZERO + {4'b0000, digit})
                                     : req_data.cipher_byte;
   end

   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full;

endmodule

// ===== src/sdcm_queue.sv =====
// short fifo between front and back
`timescale 1ns / 1ps
module sdcm_queue import sdcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  qentry_type  wdata,
   input  logic        pop,
   output qentry_type  rdata,
   output qstatus_type status
);

   qentry_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata        = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== src/sdcm_back.sv =====
// back end: history window, crib compare, latched flags and output register
`timescale 1ns / 1ps
module sdcm_back import sdcm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qstatus_type q_status,
   input  qentry_type  q_rdata,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   logic [WIN_DEPTH-1:0][7:0]    hist_ff, hist_in;
   logic [NUM_CODES-1:0]         flags_ff, flags_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;
   logic [MAX_CODE_LEN-1:0][7:0] win;
   logic [NUM_CODES-1:0]         hit;
   logic [NUM_CODES-1:0]         flags_new;

   assign q_pop = !q_status.empty && (!rsp_valid_ff || !rsp_stall);

   // window with the incoming byte at place 0
   assign win = {hist_ff, q_rdata.plain_byte};

   always_comb begin
      for (int k = 0; k < NUM_CODES; k++) begin
         hit[k] = 1'b1;
         for (int j = 0; j < MAX_CODE_LEN; j++) begin
            if ((j < int'(CRIB_LEN[k])) && (win[j] != CRIBS[k][8*j +: 8])) begin
               hit[k] = 1'b0;
            end
         end
      end
      flags_new = flags_ff | hit;
   end

   always_comb begin
      hist_in      = hist_ff;
      flags_in     = flags_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (q_pop) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.plain_byte     = q_rdata.plain_byte;
         rsp_data_in.codes_found    = flags_new;
         rsp_data_in.all_found      = (flags_new == ALL_CODES);
         rsp_data_in.end_of_message = q_rdata.last_byte;
         if (q_rdata.last_byte) begin
            hist_in  = '0;
            flags_in = '0;
         end else begin
            hist_in  = win[WIN_DEPTH-1:0];
            flags_in = flags_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hist_ff      <= hist_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/substitution_decrypt_crib_match_core.sv =====
// top level: substitution decrypt with latched crib search
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  req     | in        | req_valid / req_stall  | req_data  (req_type)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (rsp_type)
//  csr     | in        | csr_valid / csr_ready  | csr_data  (40-bit key map)
//
//  one item per cycle sustained while rsp_stall is low; an accepted item is written
//  to the queue, then popped into the back end output register, from which it shows on rsp
//  rate is set by the back end window update, one queue pop per cycle while rsp is not stalled
//  reset is synchronous: key returns to the identity map, window and flags clear
//  rsp_stall holds the output register; the two-entry queue absorbs the front
//  req_stall rises only when the queue is full
`timescale 1ns / 1ps
module substitution_decrypt_crib_match_core import sdcm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // input byte channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   // key register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [KEY_WIDTH-1:0] csr_data
);

   // queue hookup between front and back
   logic        q_push;
   logic        q_pop;
   qentry_type  q_wdata;
   qentry_type  q_rdata;
   qstatus_type q_status;

   // front: holds the key and substitutes letters a..j by their digit
   sdcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   // decoupling queue: lets the front keep taking items while rsp stalls, until the queue is full
   sdcm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // back: shifts the plain byte into the window, compares cribs, latches
   // flags, and clears the window and the flags after the last byte of a message
   sdcm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/sdcm_checker.sv =====
// port level checker for the crib match core and its bind
`timescale 1ns / 1ps
`include "substitution_decrypt_crib_match_core_macros.svh"
module sdcm_checker import sdcm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   `SDCM_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // verdict flag agrees with the found mask
   `SDCM_ASSERT_IMP(a_all_found, rsp_valid, rsp_data.all_found == (rsp_data.codes_found == ALL_CODES))
   // letters a..j never leave unsubstituted
   `SDCM_ASSERT_IMP(a_no_letter, rsp_valid, (rsp_data.plain_byte < CHAR_A) || (rsp_data.plain_byte > CHAR_J))
   // reset empties the queue and the output register: no rsp and no req stall after it
   `SDCM_ASSERT_RST(a_reset_idle, !rsp_valid && !req_stall)

endmodule

bind substitution_decrypt_crib_match_core sdcm_checker u_checker (.*);
